/* rtl/core/ssfp_pkg.sv */
package ssfp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ID  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_ID = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THIRD_ID  = 2'd2;

  // Reset values of the expected servo ids.
  localparam logic [BYTE_W-1:0] FIRST_ID_RST  = 8'h0A;
  localparam logic [BYTE_W-1:0] SECOND_ID_RST = 8'h0B;
  localparam logic [BYTE_W-1:0] THIRD_ID_RST  = 8'h0C;

  // Fixed header bytes.
  localparam logic [BYTE_W-1:0] HDR_FF    = 8'hFF;
  localparam logic [BYTE_W-1:0] HDR_FD    = 8'hFD;
  localparam logic [BYTE_W-1:0] HDR_ZERO  = 8'h00;
  localparam logic [BYTE_W-1:0] HDR_BCAST = 8'hFE;
  localparam logic [BYTE_W-1:0] HDR_LENLO = 8'h10;
  localparam logic [BYTE_W-1:0] HDR_INSTR = 8'h55;

  typedef enum logic [20:0] {
    ST_HDR1  = 21'h000001,
    ST_HDR2  = 21'h000002,
    ST_HDR3  = 21'h000004,
    ST_RSV   = 21'h000008,
    ST_BCAST = 21'h000010,
    ST_LENLO = 21'h000020,
    ST_LENHI = 21'h000040,
    ST_INSTR = 21'h000080,
    ST_ERRHD = 21'h000100,
    ST_IDA   = 21'h000200,
    ST_STA   = 21'h000400,
    ST_CRCA0 = 21'h000800,
    ST_CRCA1 = 21'h001000,
    ST_ERRA  = 21'h002000,
    ST_IDB   = 21'h004000,
    ST_STB   = 21'h008000,
    ST_CRCB0 = 21'h010000,
    ST_CRCB1 = 21'h020000,
    ST_ERRB  = 21'h040000,
    ST_IDC   = 21'h080000,
    ST_STC   = 21'h100000
  } parse_state_t;

endpackage

/* rtl/core/ssfp_if.sv */
interface ssfp_rx_if;
  logic                          valid;
  logic                          ready;
  logic [ssfp_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ssfp_flag_if;
  logic valid;
  logic ready;
  logic all_flags_set;

  modport source (output valid, output all_flags_set, input ready);
  modport sink   (input valid, input all_flags_set, output ready);
endinterface

/* rtl/core/servo_status_frame_parser.sv */
// The result transaction for a byte is presented in the cycle after the byte is accepted.
// Throughput: one byte per cycle unless the sink stalls; the single state register and one
// result register set this, and a new byte is taken in the same cycle the waiting result is.
// Reset (rst_n low, synchronous): the parser returns to the first header state, the
// kept status bits clear, the ids return to 10, 11 and 12, and no result is pending.
module servo_status_frame_parser (
  input  logic                             clk,
  input  logic                             rst_n,
  ssfp_rx_if.sink                          in_rx,
  ssfp_flag_if.source                      out_flag,
  input  logic                             cfg_we,
  input  logic [ssfp_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [ssfp_pkg::BYTE_W-1:0]      cfg_wdata
);

  // Expected servo ids of the three sub-records.
  logic [ssfp_pkg::BYTE_W-1:0] first_id_r;
  logic [ssfp_pkg::BYTE_W-1:0] second_id_r;
  logic [ssfp_pkg::BYTE_W-1:0] third_id_r;

  ssfp_pkg::parse_state_t state_r, state_nxt;
  logic first_bit_r, first_bit_nxt;
  logic second_bit_r, second_bit_nxt;

  // The result register holds one pending result transaction.
  logic out_valid_r, out_valid_nxt;
  logic out_flag_r, out_flag_nxt;
  logic flag;

  logic accept;
  logic [ssfp_pkg::BYTE_W-1:0] rx;

  // A byte is taken whenever the result register is empty or is being emptied in this
  // same cycle, so the parser keeps pace with a sink that is always ready.
  assign in_rx.ready = ~out_valid_r | out_flag.ready;
  assign accept      = in_rx.valid & in_rx.ready;
  assign rx          = in_rx.rx_byte;

  assign out_flag.valid         = out_valid_r;
  assign out_flag.all_flags_set = out_flag_r;

  // Configuration writes; an index beyond the three registers is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_id_r  <= ssfp_pkg::FIRST_ID_RST;
      second_id_r <= ssfp_pkg::SECOND_ID_RST;
      third_id_r  <= ssfp_pkg::THIRD_ID_RST;
    end else if (cfg_we) begin
      if (cfg_idx == ssfp_pkg::CFG_FIRST_ID) begin
        first_id_r <= cfg_wdata;
      end
      if (cfg_idx == ssfp_pkg::CFG_SECOND_ID) begin
        second_id_r <= cfg_wdata;
      end
      if (cfg_idx == ssfp_pkg::CFG_THIRD_ID) begin
        third_id_r <= cfg_wdata;
      end
    end
  end

  // One transition per byte. A byte that does not match the expected header byte or id
  // sends the parser back to the first header state; it is not looked at again as the
  // start of a new frame. CRC and error bytes of the sub-records pass unchecked.
  always_comb begin
    state_nxt      = ssfp_pkg::ST_HDR1;
    first_bit_nxt  = first_bit_r;
    second_bit_nxt = second_bit_r;
    flag           = 1'b0;
    unique case (state_r)
      ssfp_pkg::ST_HDR1: begin
        if (rx == ssfp_pkg::HDR_FF) state_nxt = ssfp_pkg::ST_HDR2;
      end
      ssfp_pkg::ST_HDR2: begin
        if (rx == ssfp_pkg::HDR_FF) state_nxt = ssfp_pkg::ST_HDR3;
      end
      ssfp_pkg::ST_HDR3: begin
        if (rx == ssfp_pkg::HDR_FD) state_nxt = ssfp_pkg::ST_RSV;
      end
      ssfp_pkg::ST_RSV: begin
        if (rx == ssfp_pkg::HDR_ZERO) state_nxt = ssfp_pkg::ST_BCAST;
      end
      ssfp_pkg::ST_BCAST: begin
        if (rx == ssfp_pkg::HDR_BCAST) state_nxt = ssfp_pkg::ST_LENLO;
      end
      ssfp_pkg::ST_LENLO: begin
        if (rx == ssfp_pkg::HDR_LENLO) state_nxt = ssfp_pkg::ST_LENHI;
      end
      ssfp_pkg::ST_LENHI: begin
        if (rx == ssfp_pkg::HDR_ZERO) state_nxt = ssfp_pkg::ST_INSTR;
      end
      ssfp_pkg::ST_INSTR: begin
        if (rx == ssfp_pkg::HDR_INSTR) state_nxt = ssfp_pkg::ST_ERRHD;
      end
      ssfp_pkg::ST_ERRHD: begin
        if (rx == ssfp_pkg::HDR_ZERO) state_nxt = ssfp_pkg::ST_IDA;
      end
      ssfp_pkg::ST_IDA: begin
        if (rx == first_id_r) state_nxt = ssfp_pkg::ST_STA;
      end
      ssfp_pkg::ST_STA: begin
        first_bit_nxt = rx[0];
        state_nxt     = ssfp_pkg::ST_CRCA0;
      end
      ssfp_pkg::ST_CRCA0: state_nxt = ssfp_pkg::ST_CRCA1;
      ssfp_pkg::ST_CRCA1: state_nxt = ssfp_pkg::ST_ERRA;
      ssfp_pkg::ST_ERRA:  state_nxt = ssfp_pkg::ST_IDB;
      ssfp_pkg::ST_IDB: begin
        if (rx == second_id_r) state_nxt = ssfp_pkg::ST_STB;
      end
      ssfp_pkg::ST_STB: begin
        second_bit_nxt = rx[0];
        state_nxt      = ssfp_pkg::ST_CRCB0;
      end
      ssfp_pkg::ST_CRCB0: state_nxt = ssfp_pkg::ST_CRCB1;
      ssfp_pkg::ST_CRCB1: state_nxt = ssfp_pkg::ST_ERRB;
      ssfp_pkg::ST_ERRB:  state_nxt = ssfp_pkg::ST_IDC;
      ssfp_pkg::ST_IDC: begin
        if (rx == third_id_r) state_nxt = ssfp_pkg::ST_STC;
      end
      ssfp_pkg::ST_STC: begin
        // The frame ends here; the flag is raised only if all three status bits are set.
        flag      = first_bit_r & second_bit_r & rx[0];
        state_nxt = ssfp_pkg::ST_HDR1;
      end
      default: state_nxt = ssfp_pkg::ST_HDR1;
    endcase
  end

  // The result register is loaded on every accepted byte and is cleared once the sink
  // takes it without a new byte behind it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_flag_nxt  = out_flag_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      out_flag_nxt  = flag;
    end else if (out_flag.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ssfp_pkg::ST_HDR1;
      first_bit_r  <= 1'b0;
      second_bit_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        state_r      <= state_nxt;
        first_bit_r  <= first_bit_nxt;
        second_bit_r <= second_bit_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_flag_r <= out_flag_nxt;
  end

endmodule
